// ----- design/ljrd_pkg.sv -----
package ljrd_pkg;

  localparam int MAX_LINE_WIDTH = 8192;
  localparam int MAX_LINES      = 8192;
  localparam int MAX_CODE_BITS  = 16;
  localparam int RESULT_LIMIT   = 8;
  localparam int NUM_SYMBOLS    = 16;

  localparam logic [15:0] START_VALUE = 16'd8192;

  // Configuration register indexes.
  localparam logic [2:0] CFG_COUNTS_SHORT = 3'd0;
  localparam logic [2:0] CFG_COUNTS_LONG  = 3'd1;
  localparam logic [2:0] CFG_SYMBOL_CATS  = 3'd2;
  localparam logic [2:0] CFG_LINE_WIDTH   = 3'd3;
  localparam logic [2:0] CFG_LINE_COUNT   = 3'd4;

  // Outcome of one Huffman code search.
  typedef struct packed {
    logic       done;
    logic       hit;
    logic [9:0] idx;
    logic [4:0] len;
  } srch_res_t;

  // Sample produced by the predictor for the current difference.
  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } pred_res_t;

  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [31:0] m;
    if (n >= 6'd32) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = (32'd1 << n) - 32'd1;
    end
    return m;
  endfunction

endpackage

// ----- design/ljrd_search.sv -----
module ljrd_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         bit_buf,
  input  logic [5:0]          bit_fill,
  input  logic [79:0]         code_counts,
  output ljrd_pkg::srch_res_t res
);
  import ljrd_pkg::*;

  // One code length is tried per cycle.
  logic        busy_r, busy_nxt;
  logic [4:0]  len_r, len_nxt;
  logic [15:0] code_r, code_nxt;
  logic [23:0] first_r, first_nxt;
  logic [8:0]  offset_r, offset_nxt;

  logic [3:0]  lidx;
  logic [4:0]  cnt;
  logic [5:0]  bit_pos;
  logic        cur_bit;
  logic [15:0] code_v;
  logic [23:0] code_ext;
  logic [23:0] rel;
  logic        match;
  logic        exhausted;

  always_comb begin
    lidx      = 4'(len_r - 5'd1);
    cnt       = code_counts[7'(lidx) * 7'd5 +: 5];
    bit_pos   = bit_fill - {1'b0, len_r};
    cur_bit   = bit_buf[bit_pos[4:0]];
    code_v    = {code_r[14:0], cur_bit};
    code_ext  = {8'd0, code_v};
    rel       = code_ext - first_r;
    exhausted = (len_r > 5'(MAX_CODE_BITS)) || ({1'b0, len_r} > bit_fill);
    match     = (code_ext >= first_r) && (rel < {19'd0, cnt});

    res.done = busy_r && (exhausted || match);
    res.hit  = !exhausted && match;
    res.idx  = {1'b0, offset_r} + {5'd0, rel[4:0]};
    res.len  = len_r;

    busy_nxt   = busy_r;
    len_nxt    = len_r;
    code_nxt   = code_r;
    first_nxt  = first_r;
    offset_nxt = offset_r;
    if (start) begin
      busy_nxt   = 1'b1;
      len_nxt    = 5'd1;
      code_nxt   = '0;
      first_nxt  = '0;
      offset_nxt = '0;
    end else if (busy_r) begin
      if (res.done) begin
        busy_nxt = 1'b0;
      end else begin
        len_nxt    = len_r + 5'd1;
        code_nxt   = code_v;
        first_nxt  = (first_r + {19'd0, cnt}) << 1;
        offset_nxt = offset_r + {4'd0, cnt};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    len_r    <= len_nxt;
    code_r   <= code_nxt;
    first_r  <= first_nxt;
    offset_r <= offset_nxt;
  end

endmodule

// ----- design/ljrd_pred.sv -----
module ljrd_pred (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                commit,
  input  logic [15:0]         diff,
  input  logic [13:0]         line_width,
  input  logic [13:0]         line_count,
  output ljrd_pkg::pred_res_t res
);
  import ljrd_pkg::*;

  logic [15:0] pred_even_r, pred_even_nxt;
  logic [15:0] pred_odd_r, pred_odd_nxt;
  logic [15:0] start_even_r, start_even_nxt;
  logic [15:0] start_odd_r, start_odd_nxt;
  logic [12:0] col_r, col_nxt;
  logic [12:0] line_r, line_nxt;

  logic [13:0] w_cl, h_cl;
  logic [15:0] base;
  logic        last_col;

  always_comb begin
    if (line_width < 14'd2) begin
      w_cl = 14'd2;
    end else if (line_width > 14'(MAX_LINE_WIDTH)) begin
      w_cl = 14'(MAX_LINE_WIDTH);
    end else begin
      w_cl = line_width;
    end
    if (line_count < 14'd1) begin
      h_cl = 14'd1;
    end else if (line_count > 14'(MAX_LINES)) begin
      h_cl = 14'(MAX_LINES);
    end else begin
      h_cl = line_count;
    end

    // Column 0 takes its base from the first sample of the previous line.
    if (col_r == 13'd0) begin
      base = start_even_r;
    end else if (col_r[0]) begin
      base = pred_odd_r;
    end else begin
      base = pred_even_r;
    end
    res.sample = base + diff;
    last_col   = {1'b0, col_r} >= (w_cl - 14'd1);
    res.last   = last_col && ({1'b0, line_r} >= (h_cl - 14'd1));

    pred_even_nxt  = pred_even_r;
    pred_odd_nxt   = pred_odd_r;
    start_even_nxt = start_even_r;
    start_odd_nxt  = start_odd_r;
    col_nxt        = col_r;
    line_nxt       = line_r;
    if (commit) begin
      if (res.last) begin
        pred_even_nxt  = START_VALUE;
        pred_odd_nxt   = START_VALUE;
        start_even_nxt = START_VALUE;
        start_odd_nxt  = START_VALUE;
        col_nxt        = '0;
        line_nxt       = '0;
      end else begin
        if (col_r == 13'd0) begin
          pred_even_nxt  = res.sample;
          pred_odd_nxt   = start_odd_r;
          start_even_nxt = res.sample;
        end else if (col_r[0]) begin
          pred_odd_nxt = res.sample;
          if (col_r == 13'd1) begin
            start_odd_nxt = res.sample;
          end
        end else begin
          pred_even_nxt = res.sample;
        end
        if (last_col) begin
          col_nxt  = '0;
          line_nxt = line_r + 13'd1;
        end else begin
          col_nxt = col_r + 13'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_even_r  <= START_VALUE;
      pred_odd_r   <= START_VALUE;
      start_even_r <= START_VALUE;
      start_odd_r  <= START_VALUE;
      col_r        <= '0;
      line_r       <= '0;
    end else begin
      pred_even_r  <= pred_even_nxt;
      pred_odd_r   <= pred_odd_nxt;
      start_even_r <= start_even_nxt;
      start_odd_r  <= start_odd_nxt;
      col_r        <= col_nxt;
      line_r       <= line_nxt;
    end
  end

endmodule

// ----- design/lossless_jpeg_raw_decoder.sv -----
// Lossless JPEG raw scan decoder with two interleaved column predictors.
// Input channel (in_valid/in_ready/in_scan_byte): one unstuffed scan byte per
// transaction, most significant bit first. The byte is appended to a bit
// buffer and the decoder then runs until it needs more bits, has produced
// eight results for this byte, reaches the end of the image or meets an
// invalid code. Only then is in_ready raised again.
// Output channel (out_valid/out_ready): one transaction per sample, carrying
// the sample, an end-of-image flag and an invalid-code flag.
// Sequence: an accepted byte moves the sequencer to the check state; each Huffman
// code is started from the check state and then tries one code length per cycle
// in the shared search unit, up to sixteen bits; extra bits are extracted in the
// check state; each result then waits in the output register until it is taken.
// When the receiver stalls, the sequencer holds in the emit state and no new
// byte is taken. Configuration writes (cfg_we, cfg_index, cfg_wdata) act at
// once and are meant to happen while the block is idle.
// Synchronous reset clears the bit buffer and counters, returns the
// predictors to 8192 and restores default geometry; no clearing pass is needed.
module lossless_jpeg_raw_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_scan_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_sample,
  output logic        out_end_of_image,
  output logic        out_invalid_code,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import ljrd_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  // Configuration registers.
  logic [39:0] counts_short_r, counts_long_r;
  logic [63:0] cats_r;
  logic [13:0] line_width_r, line_count_r;

  // Sequencer state.
  logic [1:0]  state_r, state_nxt;
  logic [31:0] buf_r, buf_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [3:0]  pend_r, pend_nxt;
  logic [3:0]  n_r, n_nxt;
  logic        stop_r, stop_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_sample_r, out_sample_nxt;
  logic        out_eoi_r, out_eoi_nxt;
  logic        out_inv_r, out_inv_nxt;

  srch_res_t   srch;
  pred_res_t   pred;
  logic        srch_start;
  logic        pred_commit;
  logic [15:0] diff;

  logic [5:0]  fill_pend;
  logic [31:0] xbits;
  logic [14:0] v15;
  logic [14:0] half;
  logic [15:0] pend_diff;
  logic [3:0]  sym_cat;
  logic [5:0]  fill_sym;

  ljrd_search u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (srch_start),
    .bit_buf     (buf_r),
    .bit_fill    (fill_r),
    .code_counts ({counts_long_r, counts_short_r}),
    .res         (srch)
  );

  ljrd_pred u_pred (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (pred_commit),
    .diff       (diff),
    .line_width (line_width_r),
    .line_count (line_count_r),
    .res        (pred)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_end_of_image = out_eoi_r;
  assign out_invalid_code = out_inv_r;

  always_comb begin
    // Extra bits of a pending code, sign-extended in the JPEG manner.
    fill_pend = fill_r - {2'd0, pend_r};
    xbits     = (buf_r >> fill_pend[4:0]) & low_mask({2'd0, pend_r});
    v15       = xbits[14:0];
    half      = 15'd1 << (pend_r - 4'd1);
    if (v15 < half) begin
      pend_diff = {1'b0, v15} - ((16'd1 << pend_r) - 16'd1);
    end else begin
      pend_diff = {1'b0, v15};
    end
    sym_cat  = cats_r[{srch.idx[3:0], 2'b00} +: 4];
    fill_sym = fill_r - {1'b0, srch.len};

    state_nxt      = state_r;
    buf_nxt        = buf_r;
    fill_nxt       = fill_r;
    pend_nxt       = pend_r;
    n_nxt          = n_r;
    stop_nxt       = stop_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_eoi_nxt    = out_eoi_r;
    out_inv_nxt    = out_inv_r;
    srch_start     = 1'b0;
    pred_commit    = 1'b0;
    diff           = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          buf_nxt   = {buf_r[23:0], in_scan_byte};
          fill_nxt  = fill_r + 6'd8;
          n_nxt     = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (n_r >= 4'(RESULT_LIMIT)) begin
          state_nxt = S_IDLE;
        end else if (pend_r != 4'd0) begin
          if (fill_r < {2'd0, pend_r}) begin
            state_nxt = S_IDLE;
          end else begin
            diff        = pend_diff;
            pred_commit = 1'b1;
            pend_nxt    = '0;
            fill_nxt    = fill_pend;
            buf_nxt     = buf_r & low_mask(fill_pend);
            state_nxt   = S_EMIT;
          end
        end else begin
          srch_start = 1'b1;
          state_nxt  = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (srch.done) begin
          if (srch.hit && (srch.idx < 10'(NUM_SYMBOLS))) begin
            fill_nxt = fill_sym;
            buf_nxt  = buf_r & low_mask(fill_sym);
            if (sym_cat == 4'd0) begin
              pred_commit = 1'b1;
              state_nxt   = S_EMIT;
            end else begin
              pend_nxt  = sym_cat;
              state_nxt = S_CHECK;
            end
          end else if (srch.hit || (fill_r >= 6'(MAX_CODE_BITS))) begin
            // Invalid code: report it and drop everything buffered.
            buf_nxt        = '0;
            fill_nxt       = '0;
            pend_nxt       = '0;
            out_valid_nxt  = 1'b1;
            out_sample_nxt = '0;
            out_eoi_nxt    = 1'b0;
            out_inv_nxt    = 1'b1;
            stop_nxt       = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (out_valid_r && out_ready) begin
          out_valid_nxt = 1'b0;
          n_nxt         = n_r + 4'd1;
          state_nxt     = stop_r ? S_IDLE : S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A committed sample loads the output register; the last sample of the
    // image also discards whatever remains in the bit buffer.
    if (pred_commit) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = pred.sample;
      out_eoi_nxt    = pred.last;
      out_inv_nxt    = 1'b0;
      stop_nxt       = pred.last;
      if (pred.last) begin
        buf_nxt  = '0;
        fill_nxt = '0;
        pend_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_short_r <= '0;
      counts_long_r  <= '0;
      cats_r         <= '0;
      line_width_r   <= 14'd2;
      line_count_r   <= 14'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COUNTS_SHORT: counts_short_r <= cfg_wdata[39:0];
        CFG_COUNTS_LONG:  counts_long_r  <= cfg_wdata[39:0];
        CFG_SYMBOL_CATS:  cats_r         <= cfg_wdata;
        CFG_LINE_WIDTH:   line_width_r   <= cfg_wdata[13:0];
        CFG_LINE_COUNT:   line_count_r   <= cfg_wdata[13:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      buf_r       <= '0;
      fill_r      <= '0;
      pend_r      <= '0;
      n_r         <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      buf_r       <= buf_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      n_r         <= n_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_sample_r <= out_sample_nxt;
    out_eoi_r    <= out_eoi_nxt;
    out_inv_r    <= out_inv_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 6'd32)
    else $error("bit buffer fill exceeds its width");

  a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= 4'(RESULT_LIMIT))
    else $error("too many results for one byte");

  a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EMIT))
    else $error("result offered outside the emit state");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_inv_r && out_eoi_r))
    else $error("invalid code flagged as end of image");

endmodule

// ----- dv/ljrd_checker.sv -----
// Watches the configuration port and both channels of the raw decoder. It keeps
// its own copy of the decoder state, works out the pixels that each accepted
// scan byte must produce, and compares every output transaction with the
// oldest pixel still awaited.
module ljrd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_scan_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_sample,
  input  logic        out_end_of_image,
  input  logic        out_invalid_code,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          error_count,
  output int          pixels_awaited,
  output int          pixels_seen,
  output int          eoi_seen,
  output int          invalid_seen
);
  import ljrd_pkg::*;

  typedef struct packed {
    logic [15:0] sample;
    logic        eoi;
    logic        inv;
  } pixel_t;

  pixel_t pixels_due[$];

  // Configuration copy.
  logic [39:0] counts_short;
  logic [39:0] counts_long;
  logic [63:0] categories;
  logic [13:0] width_reg;
  logic [13:0] height_reg;

  // Decoder state copy.
  logic [31:0] bitbuf;
  int unsigned bitcnt;
  int unsigned cat_waiting;
  logic [15:0] pred_even, pred_odd, start_even, start_odd;
  int unsigned col, row;

  assign pixels_awaited = pixels_due.size();

  function automatic logic [31:0] ones(input int unsigned n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  function automatic int unsigned codes_of_len(input int unsigned len);
    if (len <= 8) begin
      return 32'((counts_short >> (5 * (len - 1))) & 40'd31);
    end
    return 32'((counts_long >> (5 * (len - 9))) & 40'd31);
  endfunction

  task automatic new_image();
    bitbuf      = '0;
    bitcnt      = 0;
    cat_waiting = 0;
    pred_even   = START_VALUE;
    pred_odd    = START_VALUE;
    start_even  = START_VALUE;
    start_odd   = START_VALUE;
    col         = 0;
    row         = 0;
  endtask

  task automatic pull_bits(input int unsigned n, output logic [31:0] v);
    v = (bitbuf >> (bitcnt - n)) & ones(n);
    bitcnt -= n;
    bitbuf &= ones(bitcnt);
  endtask

  // Adds a difference to the predictor of the current column and queues the pixel.
  task automatic add_pixel(input logic [15:0] diff, output bit last);
    int unsigned w, h;
    logic [15:0] s;
    bit last_col;
    pixel_t p;
    w = (width_reg < 2) ? 2 : ((width_reg > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : width_reg);
    h = (height_reg < 1) ? 1 : ((height_reg > MAX_LINES) ? MAX_LINES : height_reg);
    if (col == 0) begin
      pred_even = start_even;
      pred_odd  = start_odd;
    end
    if (col[0] == 1'b0) begin
      s = pred_even + diff;
      pred_even = s;
    end else begin
      s = pred_odd + diff;
      pred_odd = s;
    end
    if (col == 0) start_even = s;
    else if (col == 1) start_odd = s;
    last_col = (col >= w - 1);
    last = last_col && (row >= h - 1);
    p.sample = s;
    p.eoi = last;
    p.inv = 1'b0;
    pixels_due = {pixels_due, p};
    if (last) begin
      new_image();
    end else if (last_col) begin
      col = 0;
      row++;
    end else begin
      col++;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    int n;
    bit stop, last, found;
    logic [31:0] v, code, first, offset;
    logic [15:0] diff;
    int unsigned len, cnt, used, idx, c;
    pixel_t p;
    n = 0;
    stop = 0;
    bitbuf = (bitbuf << 8) | b;
    bitcnt += 8;
    while (n < RESULT_LIMIT && !stop) begin
      if (cat_waiting != 0) begin
        c = cat_waiting;
        if (bitcnt < c) begin
          stop = 1;
        end else begin
          pull_bits(c, v);
          cat_waiting = 0;
          // A value below half the range stands for a negative difference.
          if (v < (32'd1 << (c - 1))) diff = 16'(v + 32'd65536 - ((32'd1 << c) - 32'd1));
          else diff = v[15:0];
          add_pixel(diff, last);
          n++;
          stop = last;
        end
      end else begin
        code = 0; first = 0; offset = 0; idx = 0; used = 0; found = 0;
        for (len = 1; len <= MAX_CODE_BITS && !found; len++) begin
          if (len > bitcnt) break;
          code = (code << 1) | ((bitbuf >> (bitcnt - len)) & 32'd1);
          cnt = codes_of_len(len);
          if (code >= first && code - first < cnt) begin
            idx = offset + (code - first);
            used = len;
            found = 1;
          end else begin
            offset += cnt;
            first = (first + cnt) << 1;
          end
        end
        if (found && idx < NUM_SYMBOLS) begin
          c = 32'((categories >> (4 * idx)) & 64'd15);
          pull_bits(used, v);
          if (c == 0) begin
            add_pixel(16'd0, last);
            n++;
            stop = last;
          end else begin
            cat_waiting = c;
          end
        end else if (found || bitcnt >= MAX_CODE_BITS) begin
          p.sample = '0;
          p.eoi = 1'b0;
          p.inv = 1'b1;
          pixels_due = {pixels_due, p};
          n++;
          bitbuf = '0;
          bitcnt = 0;
          cat_waiting = 0;
          stop = 1;
        end else begin
          stop = 1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      counts_short = '0;
      counts_long  = '0;
      categories   = '0;
      width_reg    = 14'd2;
      height_reg   = 14'd1;
      new_image();
      pixels_due.delete();
      error_count  = 0;
      pixels_seen  = 0;
      eoi_seen     = 0;
      invalid_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        pixels_seen++;
        if (out_end_of_image) eoi_seen++;
        if (out_invalid_code) invalid_seen++;
        if (pixels_due.size() == 0) begin
          error_count++;
          $display("%0t: unexpected pixel sample=%h eoi=%b inv=%b", $time,
                   out_sample, out_end_of_image, out_invalid_code);
        end else begin
          want = pixels_due.pop_front();
          if (out_sample !== want.sample) begin
            error_count++;
            $display("%0t: sample expected %h actual %h", $time, want.sample, out_sample);
          end
          if (out_end_of_image !== want.eoi) begin
            error_count++;
            $display("%0t: end_of_image expected %b actual %b", $time, want.eoi,
                     out_end_of_image);
          end
          if (out_invalid_code !== want.inv) begin
            error_count++;
            $display("%0t: invalid_code expected %b actual %b", $time, want.inv,
                     out_invalid_code);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNTS_SHORT: counts_short = cfg_wdata[39:0];
          CFG_COUNTS_LONG:  counts_long  = cfg_wdata[39:0];
          CFG_SYMBOL_CATS:  categories   = cfg_wdata;
          CFG_LINE_WIDTH:   width_reg    = cfg_wdata[13:0];
          CFG_LINE_COUNT:   height_reg   = cfg_wdata[13:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) decode_byte(in_scan_byte);
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Top of the raw decoder testbench. It only makes stimulus and gives the
// verdict; prediction and comparison live in the checker instantiated below.
module testbench;
  import ljrd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  // Cycles to let pass once nothing is awaited: eight codes of up to 16 bits.
  localparam int SETTLE = 250;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_scan_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_sample;
  logic        out_end_of_image;
  logic        out_invalid_code;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  int error_count, pixels_awaited, pixels_seen, eoi_seen, invalid_seen;
  int cycles = 0;
  int bytes_sent;
  bit hold_request;

  // A complete prefix code of eleven symbols: three codes of length 2, one each
  // of lengths 3 to 8 and two of length 9. Any bit string decodes with it.
  localparam logic [63:0] FULL_SHORT = (64'd3 << 5) | (64'd1 << 10) | (64'd1 << 15) |
                                       (64'd1 << 20) | (64'd1 << 25) | (64'd1 << 30) |
                                       (64'd1 << 35);
  localparam logic [63:0] FULL_LONG  = 64'd2;
  // Symbol 0 carries no extra bits, symbol 1 the widest difference.
  localparam logic [63:0] FULL_CATS  = 64'h0000_0987_6543_21F0;
  // Thirty-one codes of length 5: symbol indexes past fifteen and one code left unused.
  localparam logic [63:0] WIDE_SHORT = 64'd31 << 20;

  lossless_jpeg_raw_decoder i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_scan_byte, .out_valid, .out_ready,
    .out_sample, .out_end_of_image, .out_invalid_code, .cfg_we, .cfg_index, .cfg_wdata
  );

  ljrd_checker i_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_scan_byte, .out_valid, .out_ready,
    .out_sample, .out_end_of_image, .out_invalid_code, .cfg_we, .cfg_index, .cfg_wdata,
    .error_count, .pixels_awaited, .pixels_seen, .eoi_seen, .invalid_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: switches between stretches of constant readiness, coin-flip
  // stalls and heavy stalls. On request it holds off once for a long stretch
  // so that the decoder fills up and refuses further bytes.
  initial begin
    int mode, stretch;
    bit held;
    out_ready = 1'b0;
    held = 0;
    forever begin
      if (hold_request && !held) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      stretch = $urandom_range(5, 60);
      repeat (stretch) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Offers one byte and returns at the edge where the transaction completes.
  // in_ready only moves on a rising edge, so the value seen at the falling edge
  // is the one that the next rising edge uses.
  task automatic send_byte(input logic [7:0] b);
    bit rdy;
    in_valid <= 1'b1;
    in_scan_byte <= b;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    bytes_sent++;
  endtask

  // Bursts of random length with random gaps between them.
  int burst_left;
  task automatic paced_byte(input logic [7:0] b);
    send_byte(b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every awaited pixel has arrived and the decoder has had time to
  // finish any work that yields nothing.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_awaited != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_tables(input logic [63:0] cs, input logic [63:0] cl,
                            input logic [63:0] cats, input logic [63:0] w,
                            input logic [63:0] h);
    write_reg(CFG_COUNTS_SHORT, cs);
    write_reg(CFG_COUNTS_LONG, cl);
    write_reg(CFG_SYMBOL_CATS, cats);
    write_reg(CFG_LINE_WIDTH, w);
    write_reg(CFG_LINE_COUNT, h);
  endtask

  initial begin
    logic [63:0] rnd_cats;
    int phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_scan_byte = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_COUNTS_SHORT;
    cfg_wdata = '0;
    bytes_sent = 0;
    burst_left = 0;
    hold_request = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default tables hold no codes: every sixteen bits give an invalid code.
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();

    // Two-pixel images so that the end of image comes round often; the byte
    // extremes exercise the zero category and the widest difference.
    set_tables(FULL_SHORT, FULL_LONG, FULL_CATS, 64'd2, 64'd1);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(8'h55);
    send_byte(8'hAA);
    drain();

    // Symbol indexes beyond fifteen, and an unused code, flag invalid codes.
    set_tables(WIDE_SHORT, 64'd0, FULL_CATS, 64'd3, 64'd2);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h08);
    drain();

    // Oversubscribed counts are exercised, and geometry below the legal range is clamped.
    set_tables({24'd0, {8{5'd31}}}, {24'd0, {8{5'd31}}}, 64'hFFFF_FFFF_FFFF_FFFF,
               64'd0, 64'd0);
    send_byte(8'h3C);
    send_byte(8'hC3);
    send_byte(8'h00);
    drain();

    // Random part: mostly the complete code with random categories, so that
    // every byte decodes, plus a few phases with random tables.
    for (phase = 0; phase < 8; phase++) begin
      rnd_cats = {$urandom, $urandom};
      case (phase)
        0: set_tables(FULL_SHORT, FULL_LONG, rnd_cats, 64'd5, 64'd3);
        1: set_tables(FULL_SHORT, FULL_LONG, rnd_cats, 64'd8192, 64'd8192);
        2: set_tables(FULL_SHORT, FULL_LONG, rnd_cats, 64'h3FFF, 64'h3FFF);
        3: set_tables({$urandom, $urandom}, {$urandom, $urandom}, rnd_cats,
                      $urandom_range(0, 9), $urandom_range(0, 4));
        4: set_tables(FULL_SHORT, FULL_LONG, FULL_CATS, 64'd3, 64'd4);
        5: set_tables(WIDE_SHORT, 64'd0, rnd_cats, 64'd4, 64'd2);
        default: set_tables(FULL_SHORT, FULL_LONG, rnd_cats, $urandom_range(2, 12),
                            $urandom_range(1, 5));
      endcase
      if (phase == 1) hold_request = 1;
      repeat (50) paced_byte($urandom_range(0, 255));
      drain();
    end

    $display("Run covered %0d scan bytes, %0d pixels, %0d image ends, %0d invalid codes.",
             bytes_sent, pixels_seen, eoi_seen, invalid_seen);
    $display("Tables: empty, complete, oversubscribed, out-of-range symbols and random.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
